// ===== src/analog_axis_dead_zone_scaler_unit_assert.svh =====
// ----------------------------------------------------------------------------
// analog axis dead zone scaler assertion macros
// shared assertion shorthands for the scaler rtl
// ----------------------------------------------------------------------------
`ifndef ANALOG_AXIS_DEAD_ZONE_SCALER_UNIT_ASSERT_SVH
`define ANALOG_AXIS_DEAD_ZONE_SCALER_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ADZS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ADZS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/adzs_pkg.sv =====
// ----------------------------------------------------------------------------
// adzs_pkg
// types and constants shared by the dead zone scaler modules
// ----------------------------------------------------------------------------
package adzs_pkg;

  localparam int SQRT_STAGES = 8;
  localparam int DIV_STEPS   = 15;

  localparam logic [15:0] Q15_MAX = 16'h7FFF;

  localparam logic [14:0] TRIG_DZ_RST  = 15'd250;
  localparam logic [15:0] TRIG_FS_RST  = 16'd30000;
  localparam logic [15:0] STICK_DZ_RST = 16'd8000;
  localparam logic [15:0] STICK_FS_RST = 16'd30000;

  typedef enum logic [1:0] {
    CFG_TRIG_DZ  = 2'd0,
    CFG_TRIG_FS  = 2'd1,
    CFG_STICK_DZ = 2'd2,
    CFG_STICK_FS = 2'd3
  } cfg_idx_t;

  // sample in flight before the radius is known
  typedef struct packed {
    logic        vld;
    logic        mode;
    logic        neg_x;
    logic        neg_y;
    logic [15:0] ax;
    logic [15:0] ay;
  } smp_t;

  // control carried through the divider
  typedef struct packed {
    logic vld;
    logic mode;
    logic neg_x;
    logic neg_y;
    logic zero;
  } tag_t;

endpackage

// ===== src/adzs_isqrt.sv =====
// ----------------------------------------------------------------------------
// adzs_isqrt
// pipelined integer square root, two result bits per stage
// ----------------------------------------------------------------------------
module adzs_isqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  adzs_pkg::smp_t     in_smp,
  input  logic [31:0]        in_sq,
  output adzs_pkg::smp_t     out_smp,
  output logic [15:0]        out_len
);
  import adzs_pkg::*;

  typedef struct packed {
    logic [19:0] rem;
    logic [15:0] root;
  } sq_st_t;

  function automatic sq_st_t sq_step(input sq_st_t s, input logic [1:0] d);
    logic [19:0] rs;
    logic [19:0] tr;
    sq_st_t      o;
    rs = {s.rem[17:0], d};
    tr = {2'b00, s.root, 2'b01};
    if (rs >= tr) begin
      o.rem  = rs - tr;
      o.root = {s.root[14:0], 1'b1};
    end else begin
      o.rem  = rs;
      o.root = {s.root[14:0], 1'b0};
    end
    return o;
  endfunction

  smp_t        smp_r   [SQRT_STAGES];
  smp_t        smp_nxt [SQRT_STAGES];
  logic [31:0] v_r     [SQRT_STAGES];
  logic [31:0] v_nxt   [SQRT_STAGES];
  sq_st_t      st_r    [SQRT_STAGES];
  sq_st_t      st_nxt  [SQRT_STAGES];

  always_comb begin
    sq_st_t      prev_st;
    sq_st_t      mid_st;
    logic [31:0] prev_v;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (k == 0) begin
        prev_st    = '0;
        prev_v     = in_sq;
        smp_nxt[k] = in_smp;
      end else begin
        prev_st    = st_r[k-1];
        prev_v     = v_r[k-1];
        smp_nxt[k] = smp_r[k-1];
      end
      mid_st    = sq_step(prev_st, prev_v[31:30]);
      st_nxt[k] = sq_step(mid_st, prev_v[29:28]);
      // two digit pairs consumed per stage
      v_nxt[k]  = {prev_v[27:0], 4'b0000};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (!rst_n) begin
        smp_r[k] <= '0;
      end else begin
        smp_r[k] <= smp_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQRT_STAGES; k++) begin
      v_r[k]  <= v_nxt[k];
      st_r[k] <= st_nxt[k];
    end
  end

  assign out_smp = smp_r[SQRT_STAGES-1];
  assign out_len = st_r[SQRT_STAGES-1].root;

endmodule

// ===== src/adzs_div.sv =====
// ----------------------------------------------------------------------------
// adzs_div
// two-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module adzs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  adzs_pkg::tag_t     in_tag,
  input  logic [31:0]        in_nx,
  input  logic [31:0]        in_ny,
  input  logic [31:0]        in_d,
  output adzs_pkg::tag_t     out_tag,
  output logic [14:0]        out_qx,
  output logic [14:0]        out_qy,
  output logic               out_sat_x,
  output logic               out_sat_y
);
  import adzs_pkg::*;

  // one restoring step: returns {new remainder, quotient bit}
  function automatic logic [32:0] div_step(input logic [31:0] r, input logic [31:0] d);
    logic [32:0] t;
    logic [32:0] dd;
    logic [32:0] o;
    t  = {r, 1'b0};
    dd = {1'b0, d};
    if (t >= dd) begin
      o = {32'(t - dd), 1'b1};
    end else begin
      o = {t[31:0], 1'b0};
    end
    return o;
  endfunction

  tag_t        tag_r   [DIV_STEPS];
  tag_t        tag_nxt [DIV_STEPS];
  logic [31:0] d_r     [DIV_STEPS];
  logic [31:0] d_nxt   [DIV_STEPS];
  logic [31:0] rx_r    [DIV_STEPS];
  logic [31:0] rx_nxt  [DIV_STEPS];
  logic [31:0] ry_r    [DIV_STEPS];
  logic [31:0] ry_nxt  [DIV_STEPS];
  logic [14:0] qx_r    [DIV_STEPS];
  logic [14:0] qx_nxt  [DIV_STEPS];
  logic [14:0] qy_r    [DIV_STEPS];
  logic [14:0] qy_nxt  [DIV_STEPS];
  logic        sx_r    [DIV_STEPS];
  logic        sx_nxt  [DIV_STEPS];
  logic        sy_r    [DIV_STEPS];
  logic        sy_nxt  [DIV_STEPS];

  always_comb begin
    logic [31:0] prx;
    logic [31:0] pry;
    logic [31:0] pd;
    logic [14:0] pqx;
    logic [14:0] pqy;
    logic [32:0] ox;
    logic [32:0] oy;
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (k == 0) begin
        prx        = in_nx;
        pry        = in_ny;
        pd         = in_d;
        pqx        = '0;
        pqy        = '0;
        tag_nxt[k] = in_tag;
        // quotient of a whole or more saturates
        sx_nxt[k]  = (in_nx >= in_d);
        sy_nxt[k]  = (in_ny >= in_d);
      end else begin
        prx        = rx_r[k-1];
        pry        = ry_r[k-1];
        pd         = d_r[k-1];
        pqx        = qx_r[k-1];
        pqy        = qy_r[k-1];
        tag_nxt[k] = tag_r[k-1];
        sx_nxt[k]  = sx_r[k-1];
        sy_nxt[k]  = sy_r[k-1];
      end
      ox        = div_step(prx, pd);
      oy        = div_step(pry, pd);
      rx_nxt[k] = ox[32:1];
      ry_nxt[k] = oy[32:1];
      qx_nxt[k] = {pqx[13:0], ox[0]};
      qy_nxt[k] = {pqy[13:0], oy[0]};
      d_nxt[k]  = pd;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (!rst_n) begin
        tag_r[k] <= '0;
      end else begin
        tag_r[k] <= tag_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      d_r[k]  <= d_nxt[k];
      rx_r[k] <= rx_nxt[k];
      ry_r[k] <= ry_nxt[k];
      qx_r[k] <= qx_nxt[k];
      qy_r[k] <= qy_nxt[k];
      sx_r[k] <= sx_nxt[k];
      sy_r[k] <= sy_nxt[k];
    end
  end

  assign out_tag   = tag_r[DIV_STEPS-1];
  assign out_qx    = qx_r[DIV_STEPS-1];
  assign out_qy    = qy_r[DIV_STEPS-1];
  assign out_sat_x = sx_r[DIV_STEPS-1];
  assign out_sat_y = sy_r[DIV_STEPS-1];

endmodule

// ===== src/analog_axis_dead_zone_scaler_unit.sv =====
// ----------------------------------------------------------------------------
// analog_axis_dead_zone_scaler_unit
// trigger and stick dead zone removal with rescaling to q1.15
// ----------------------------------------------------------------------------
// usage:
//   a sample (in_mode, in_raw_x, in_raw_y) is taken on a rising edge with
//   start high and busy low. busy is held low, so a new sample can be given
//   on every cycle and one result leaves per cycle.
//   each result appears on out_scaled_x / out_scaled_y for one cycle with
//   out_strobe high, in the order the samples came in. the receiver
//   cannot stall the output. the pipeline holds the input and squaring
//   stages, eight square-root stages (two root bits each), scale and
//   multiply stages, fifteen divider stages (one quotient bit each) and
//   the output register.
//   the cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   four dead zone and full scale registers; cfg_ready is always high.
//   registers should only be changed while no sample is in flight.
//   synchronous reset empties the pipeline and restores the register
//   defaults (250, 30000, 8000, 30000).
// ----------------------------------------------------------------------------
module analog_axis_dead_zone_scaler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [15:0] in_raw_x,
  input  logic [15:0] in_raw_y,
  output logic        out_strobe,
  output logic [15:0] out_scaled_x,
  output logic [15:0] out_scaled_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import adzs_pkg::*;
  `include "analog_axis_dead_zone_scaler_unit_assert.svh"

  // configuration
  logic [14:0] trig_dz_r;
  logic [15:0] trig_fs_r;
  logic [15:0] stick_dz_r;
  logic [15:0] stick_fs_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_dz_r  <= TRIG_DZ_RST;
      trig_fs_r  <= TRIG_FS_RST;
      stick_dz_r <= STICK_DZ_RST;
      stick_fs_r <= STICK_FS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TRIG_DZ:  trig_dz_r  <= cfg_data[14:0];
        CFG_TRIG_FS:  trig_fs_r  <= cfg_data;
        CFG_STICK_DZ: stick_dz_r <= cfg_data;
        CFG_STICK_FS: stick_fs_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage a: magnitudes and signs
  smp_t a_smp_r, a_smp_nxt;

  always_comb begin
    a_smp_nxt.vld   = start && !busy;
    a_smp_nxt.mode  = in_mode;
    a_smp_nxt.neg_x = in_raw_x[15];
    a_smp_nxt.neg_y = in_raw_y[15];
    a_smp_nxt.ax    = in_raw_x[15] ? 16'(~in_raw_x + 16'd1) : in_raw_x;
    a_smp_nxt.ay    = in_raw_y[15] ? 16'(~in_raw_y + 16'd1) : in_raw_y;
  end

  // stage b: squares, stage c: sum
  smp_t        b_smp_r;
  logic [31:0] b_sqx_r, b_sqy_r;
  smp_t        c_smp_r;
  logic [31:0] c_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_smp_r <= '0;
      b_smp_r <= '0;
      c_smp_r <= '0;
    end else begin
      a_smp_r <= a_smp_nxt;
      b_smp_r <= a_smp_r;
      c_smp_r <= b_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    b_sqx_r <= a_smp_r.ax * a_smp_r.ax;
    b_sqy_r <= a_smp_r.ay * a_smp_r.ay;
    // at most 2^31, fits
    c_sum_r <= 32'(b_sqx_r + b_sqy_r);
  end

  smp_t        s_smp;
  logic [15:0] s_len;

  adzs_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_smp  (c_smp_r),
    .in_sq   (c_sum_r),
    .out_smp (s_smp),
    .out_len (s_len)
  );

  // stage m: scale fraction num/den; the trigger rides the same path as
  // num/den with unit multiplicands
  tag_t        m_tag_r, m_tag_nxt;
  logic [15:0] m_mx_r, m_mx_nxt;
  logic [15:0] m_my_r, m_my_nxt;
  logic [15:0] m_num_r, m_num_nxt;
  logic [15:0] m_den_r, m_den_nxt;
  logic [15:0] m_len_r, m_len_nxt;

  always_comb begin
    logic        s_hit, s_fold, t_hit, t_fold;
    logic [15:0] s_den, s_dl, t_dz;
    t_dz   = {1'b0, trig_dz_r};
    s_hit  = (s_len >= stick_dz_r) && (s_len != 16'd0);
    s_fold = (stick_fs_r <= stick_dz_r);
    s_den  = 16'(stick_fs_r - stick_dz_r);
    s_dl   = 16'(s_len - stick_dz_r);
    t_hit  = (s_smp.ax > t_dz);
    t_fold = (trig_fs_r <= t_dz);

    m_tag_nxt.vld   = s_smp.vld;
    m_tag_nxt.mode  = s_smp.mode;
    m_tag_nxt.neg_x = s_smp.neg_x;
    m_tag_nxt.neg_y = s_smp.neg_y;
    m_my_nxt        = s_smp.ay;
    if (s_smp.mode) begin
      m_tag_nxt.zero = !s_hit;
      m_mx_nxt       = s_smp.ax;
      m_len_nxt      = s_len;
      if (s_fold) begin
        m_num_nxt = 16'd1;
        m_den_nxt = 16'd1;
      end else begin
        m_den_nxt = s_den;
        m_num_nxt = (s_dl > s_den) ? s_den : s_dl;
      end
    end else begin
      m_tag_nxt.zero = !t_hit;
      m_mx_nxt       = 16'd1;
      m_len_nxt      = 16'd1;
      if (t_fold) begin
        m_num_nxt = 16'd1;
        m_den_nxt = 16'd1;
      end else begin
        m_num_nxt = 16'(s_smp.ax - t_dz);
        m_den_nxt = 16'(trig_fs_r - t_dz);
      end
    end
  end

  // stage p: products for the divider
  tag_t        p_tag_r;
  logic [31:0] p_nx_r, p_ny_r, p_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_tag_r <= '0;
      p_tag_r <= '0;
    end else begin
      m_tag_r <= m_tag_nxt;
      p_tag_r <= m_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    m_mx_r  <= m_mx_nxt;
    m_my_r  <= m_my_nxt;
    m_num_r <= m_num_nxt;
    m_den_r <= m_den_nxt;
    m_len_r <= m_len_nxt;
    p_nx_r  <= m_mx_r * m_num_r;
    p_ny_r  <= m_my_r * m_num_r;
    p_d_r   <= m_den_r * m_len_r;
  end

  tag_t        d_tag;
  logic [14:0] d_qx, d_qy;
  logic        d_sat_x, d_sat_y;

  adzs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tag    (p_tag_r),
    .in_nx     (p_nx_r),
    .in_ny     (p_ny_r),
    .in_d      (p_d_r),
    .out_tag   (d_tag),
    .out_qx    (d_qx),
    .out_qy    (d_qy),
    .out_sat_x (d_sat_x),
    .out_sat_y (d_sat_y)
  );

  // output register: saturate, zero, sign
  logic        out_strobe_r;
  logic [15:0] out_x_r, out_x_nxt;
  logic [15:0] out_y_r, out_y_nxt;
  logic        o_mode_r, o_zero_r;

  always_comb begin
    logic [15:0] mag_x, mag_y;
    mag_x = d_sat_x ? Q15_MAX : {1'b0, d_qx};
    mag_y = d_sat_y ? Q15_MAX : {1'b0, d_qy};
    if (d_tag.zero) begin
      mag_x = '0;
      mag_y = '0;
    end
    if (!d_tag.mode) begin
      mag_y = '0;
    end
    out_x_nxt = d_tag.neg_x ? 16'(~mag_x + 16'd1) : mag_x;
    out_y_nxt = d_tag.neg_y ? 16'(~mag_y + 16'd1) : mag_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= d_tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r  <= out_x_nxt;
    out_y_r  <= out_y_nxt;
    o_mode_r <= d_tag.mode;
    o_zero_r <= d_tag.zero;
  end

  assign out_strobe   = out_strobe_r;
  assign out_scaled_x = out_x_r;
  assign out_scaled_y = out_y_r;

  `ADZS_ASSERT_NOW(a_trig_y_zero, out_strobe && !o_mode_r, out_scaled_y == 16'd0, "trigger result has nonzero y")
  `ADZS_ASSERT_NOW(a_dead_zero, out_strobe && o_zero_r, out_scaled_x == 16'd0 && out_scaled_y == 16'd0, "dead zone result not zero")
  `ADZS_ASSERT_NOW(a_no_min, out_strobe, out_scaled_x != 16'h8000 && out_scaled_y != 16'h8000, "result magnitude above saturation")

endmodule
